FILE: rtl/core/gmm_pkg.sv
// ----------------------------------------------------------------------------
// gmm_pkg
// Shared types, constants and the base decoder of the gapped motif matcher.
// ----------------------------------------------------------------------------
package gmm_pkg;

  localparam int SITE_LEN_MAX = 32;
  localparam int WINDOW_DEPTH = 256;

  localparam int PAT_W    = 64;
  localparam int LEN_W    = 6;
  localparam int OFF_W    = 8;
  localparam int WHOLE_W  = 9;
  localparam int COUNT_W  = 32;
  localparam int ENTRY_W  = 3;
  localparam int CODE_W   = 2;
  localparam int IDX_W    = 3;
  localparam int DIST_W   = $clog2(WINDOW_DEPTH);
  localparam int POS_W    = 12;
  localparam int DIFF_W   = COUNT_W + 2;
  localparam int GROUP    = 16;
  localparam int NGROUP   = WINDOW_DEPTH / GROUP;

  localparam logic signed [POS_W-1:0] POS_ONE       = POS_W'(1);
  localparam logic signed [POS_W-1:0] POS_LAST_DIST = POS_W'(WINDOW_DEPTH - 1);

  localparam logic [CODE_W-1:0] BASE_A = 2'd0;
  localparam logic [CODE_W-1:0] BASE_C = 2'd1;
  localparam logic [CODE_W-1:0] BASE_G = 2'd2;
  localparam logic [CODE_W-1:0] BASE_T = 2'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_SITE1_PAT   = 3'd0,
    REG_SITE1_LEN   = 3'd1,
    REG_SITE1_OFF   = 3'd2,
    REG_SITE2_PAT   = 3'd3,
    REG_SITE2_LEN   = 3'd4,
    REG_SITE2_OFF   = 3'd5,
    REG_WHOLE_LEN   = 3'd6,
    REG_MINUS       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PAT_W-1:0]        pat;
    logic signed [POS_W-1:0] lo;
    logic [LEN_W-1:0]        len;
    logic                    en;
  } site_t;

  typedef struct packed {
    site_t s1;
    site_t s2;
    logic  minus;
  } cmp_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] last;
    logic                    too_far;
  } span_t;

  // {valid, code}; anything but acgt in either case is an invalid base
  function automatic logic [ENTRY_W-1:0] decode_base(logic [7:0] b);
    logic [ENTRY_W-1:0] e;
    case (b)
      "a", "A": e = {1'b1, BASE_A};
      "c", "C": e = {1'b1, BASE_C};
      "g", "G": e = {1'b1, BASE_G};
      "t", "T": e = {1'b1, BASE_T};
      default:  e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/core/gmm_cell.sv
// ----------------------------------------------------------------------------
// gmm_cell
// One history cell: holds a base, passes it on, checks it against both sites.
// ----------------------------------------------------------------------------
module gmm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift_en,
  input  logic                         flush,
  input  logic [gmm_pkg::ENTRY_W-1:0]  prev_entry,
  input  logic [gmm_pkg::DIST_W-1:0]   distance,
  input  gmm_pkg::cmp_cfg_t            cmp,
  output logic [gmm_pkg::ENTRY_W-1:0]  entry,
  output logic                         ok
);

  logic                        vld;
  logic [gmm_pkg::CODE_W-1:0]  code;

  function automatic logic site_ok(gmm_pkg::site_t s, logic minus,
                                   logic [gmm_pkg::DIST_W-1:0] d,
                                   logic e_vld, logic [gmm_pkg::CODE_W-1:0] e_code);
    logic signed [gmm_pkg::POS_W-1:0] k;
    logic [gmm_pkg::LEN_W-1:0]        j;
    logic [gmm_pkg::CODE_W-1:0]       want;
    logic                             req;
    k    = $signed({{(gmm_pkg::POS_W-gmm_pkg::DIST_W){1'b0}}, d}) - s.lo;
    req  = s.en && !k[gmm_pkg::POS_W-1] &&
           (k < $signed({{(gmm_pkg::POS_W-gmm_pkg::LEN_W){1'b0}}, s.len}));
    j    = minus ? k[gmm_pkg::LEN_W-1:0]
                 : (s.len - gmm_pkg::LEN_W'(1) - k[gmm_pkg::LEN_W-1:0]);
    want = s.pat[{j[gmm_pkg::LEN_W-2:0], 1'b0} +: gmm_pkg::CODE_W] ^ {gmm_pkg::CODE_W{minus}};
    return !req || (e_vld && e_code == want);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift_en) begin
      vld <= !flush && prev_entry[gmm_pkg::ENTRY_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      code <= prev_entry[gmm_pkg::CODE_W-1:0];
    end
  end

  assign entry = {vld, code};
  assign ok    = site_ok(cmp.s1, cmp.minus, distance, vld, code) &&
                 site_ok(cmp.s2, cmp.minus, distance, vld, code);

endmodule

FILE: rtl/core/gmm_cfg.sv
// ----------------------------------------------------------------------------
// gmm_cfg
// Configuration registers and the site placement derived from them.
// ----------------------------------------------------------------------------
module gmm_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  logic [gmm_pkg::IDX_W-1:0]    index,
  input  logic [gmm_pkg::PAT_W-1:0]    data,
  output gmm_pkg::cmp_cfg_t            cmp,
  output gmm_pkg::span_t               span
);

  logic [gmm_pkg::PAT_W-1:0]   pat1;
  logic [gmm_pkg::LEN_W-1:0]   len1;
  logic [gmm_pkg::OFF_W-1:0]   off1;
  logic [gmm_pkg::PAT_W-1:0]   pat2;
  logic [gmm_pkg::LEN_W-1:0]   len2;
  logic [gmm_pkg::OFF_W-1:0]   off2;
  logic [gmm_pkg::WHOLE_W-1:0] whole;
  logic                        minus;

  logic [gmm_pkg::LEN_W-1:0]        l1, l2;
  logic                             use2;
  logic signed [gmm_pkg::POS_W-1:0] l1s, l2s, f1s, f2s, ws;
  logic signed [gmm_pkg::POS_W-1:0] o1, o2, e1, e2, last, lo1, lo2, t1, t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat1  <= '0;
      len1  <= gmm_pkg::LEN_W'(1);
      off1  <= '0;
      pat2  <= '0;
      len2  <= '0;
      off2  <= '0;
      whole <= gmm_pkg::WHOLE_W'(1);
      minus <= 1'b0;
    end else if (wr) begin
      case (gmm_pkg::reg_idx_t'(index))
        gmm_pkg::REG_SITE1_PAT: pat1  <= data;
        gmm_pkg::REG_SITE1_LEN: len1  <= data[gmm_pkg::LEN_W-1:0];
        gmm_pkg::REG_SITE1_OFF: off1  <= data[gmm_pkg::OFF_W-1:0];
        gmm_pkg::REG_SITE2_PAT: pat2  <= data;
        gmm_pkg::REG_SITE2_LEN: len2  <= data[gmm_pkg::LEN_W-1:0];
        gmm_pkg::REG_SITE2_OFF: off2  <= data[gmm_pkg::OFF_W-1:0];
        gmm_pkg::REG_WHOLE_LEN: whole <= data[gmm_pkg::WHOLE_W-1:0];
        gmm_pkg::REG_MINUS:     minus <= data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    l1   = (len1 > gmm_pkg::LEN_W'(gmm_pkg::SITE_LEN_MAX)) ?
           gmm_pkg::LEN_W'(gmm_pkg::SITE_LEN_MAX) : len1;
    l2   = (len2 > gmm_pkg::LEN_W'(gmm_pkg::SITE_LEN_MAX)) ?
           gmm_pkg::LEN_W'(gmm_pkg::SITE_LEN_MAX) : len2;
    use2 = (len2 != '0);
    l1s  = $signed({{(gmm_pkg::POS_W-gmm_pkg::LEN_W){1'b0}}, l1});
    l2s  = $signed({{(gmm_pkg::POS_W-gmm_pkg::LEN_W){1'b0}}, l2});
    f1s  = $signed({{(gmm_pkg::POS_W-gmm_pkg::OFF_W){1'b0}}, off1});
    f2s  = $signed({{(gmm_pkg::POS_W-gmm_pkg::OFF_W){1'b0}}, off2});
    ws   = $signed({{(gmm_pkg::POS_W-gmm_pkg::WHOLE_W){1'b0}}, whole});

    // mirrored placement on the minus strand
    o1   = minus ? (ws - f1s - l1s) : f1s;
    o2   = minus ? (ws - f2s - l2s) : f2s;
    e1   = o1 + l1s;
    e2   = o2 + l2s;
    last = (use2 && (e2 > e1)) ? e2 : e1;
    lo1  = last - e1;
    lo2  = last - e2;
    t1   = lo1 + l1s - gmm_pkg::POS_ONE;
    t2   = lo2 + l2s - gmm_pkg::POS_ONE;

    cmp.s1.pat = pat1;
    cmp.s1.lo  = lo1;
    cmp.s1.len = l1;
    cmp.s1.en  = 1'b1;
    cmp.s2.pat = pat2;
    cmp.s2.lo  = lo2;
    cmp.s2.len = l2;
    cmp.s2.en  = use2;
    cmp.minus  = minus;

    span.last    = last;
    span.too_far = ((l1 != '0) && (t1 > gmm_pkg::POS_LAST_DIST)) ||
                   (use2 && (t2 > gmm_pkg::POS_LAST_DIST));
  end

endmodule

FILE: rtl/core/gapped_motif_matcher.sv
// ----------------------------------------------------------------------------
// gapped_motif_matcher
// Streaming gapped DNA motif search over a shifting chain of history cells.
// ----------------------------------------------------------------------------
// Pipeline: history cells (stage A), stage B registers, output register (stage C).
// Throughput: one word per cycle unless in_stall is high; three words can be in
//   flight, and a new word is taken while a result waits at the output if A or B is free.
// Reset: history cells invalid, base count and sticky flag cleared,
//   registers at their defaults. The configuration port is always ready.
// ----------------------------------------------------------------------------
module gapped_motif_matcher (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    base_byte,
  input  logic                          sequence_start,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          match_found,
  output logic [gmm_pkg::COUNT_W-1:0]   start_position,
  output logic                          any_match,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [gmm_pkg::PAT_W-1:0]     cfg_data
);

  gmm_pkg::cmp_cfg_t cmp;
  gmm_pkg::span_t    span;

  logic accept;
  logic b_ready, c_ready;

  // stage A: history chain and count
  logic                          a_valid;
  logic                          a_seq;
  logic [gmm_pkg::COUNT_W-1:0]   count;
  logic [gmm_pkg::ENTRY_W-1:0]   ent [gmm_pkg::WINDOW_DEPTH];
  logic [gmm_pkg::WINDOW_DEPTH-1:0] cell_ok;
  logic [gmm_pkg::ENTRY_W-1:0]   new_entry;

  // stage B: group results and start
  logic                          b_valid;
  logic                          b_seq;
  logic                          b_gate;
  logic [gmm_pkg::NGROUP-1:0]    b_grp;
  logic [gmm_pkg::COUNT_W-1:0]   b_start;

  logic signed [gmm_pkg::DIFF_W-1:0] diff;
  logic [gmm_pkg::NGROUP-1:0]        grp;
  logic                              hit;
  logic                              seen_next;

  assign cfg_ready = 1'b1;

  gmm_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cmp   (cmp),
    .span  (span)
  );

  assign c_ready  = !out_valid || !out_stall;
  assign b_ready  = !b_valid || c_ready;
  assign in_stall = a_valid && !b_ready;
  assign accept   = in_valid && !in_stall;

  assign new_entry = gmm_pkg::decode_base(base_byte);

  for (genvar i = 0; i < gmm_pkg::WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      gmm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift_en   (accept),
        .flush      (1'b0),
        .prev_entry (new_entry),
        .distance   (gmm_pkg::DIST_W'(i)),
        .cmp        (cmp),
        .entry      (ent[i]),
        .ok         (cell_ok[i])
      );
    end else begin : g_body
      gmm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift_en   (accept),
        .flush      (sequence_start),
        .prev_entry (ent[i-1]),
        .distance   (gmm_pkg::DIST_W'(i)),
        .cmp        (cmp),
        .entry      (ent[i]),
        .ok         (cell_ok[i])
      );
    end
  end

  for (genvar g = 0; g < gmm_pkg::NGROUP; g++) begin : g_grp
    assign grp[g] = &cell_ok[g*gmm_pkg::GROUP +: gmm_pkg::GROUP];
  end

  // stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      count   <= '0;
    end else begin
      if (b_ready || !a_valid) begin
        a_valid <= accept;
      end
      if (accept) begin
        if (sequence_start) begin
          count <= gmm_pkg::COUNT_W'(1);
        end else if (count != '1) begin
          count <= count + gmm_pkg::COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_seq <= sequence_start;
    end
  end

  // stage B
  assign diff = $signed({2'b00, count}) -
                $signed({{(gmm_pkg::DIFF_W-gmm_pkg::POS_W){span.last[gmm_pkg::POS_W-1]}},
                         span.last});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_seq   <= a_seq;
      b_grp   <= grp;
      b_gate  <= !diff[gmm_pkg::DIFF_W-1] && !span.too_far;
      b_start <= diff[gmm_pkg::COUNT_W] ? '1 : diff[gmm_pkg::COUNT_W-1:0];
    end
  end

  // stage C: output register
  assign hit       = (&b_grp) && b_gate;
  assign seen_next = (!b_seq && any_match) || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      any_match <= 1'b0;
    end else if (c_ready) begin
      out_valid <= b_valid;
      if (b_valid) begin
        any_match <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      match_found    <= hit;
      start_position <= hit ? b_start : '0;
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gapped_motif_matcher. Streams base words with
// planted gapped motifs, broken copies and noise under a series of register
// settings, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        match;
  logic [31:0] pos;
  logic        any;
} motif_result_t;

class motif_scoreboard;
  bit [63:0] pat1, pat2;
  bit [5:0]  len1, len2;
  bit [7:0]  off1, off2;
  bit [8:0]  whole;
  bit        minus;

  bit [2:0]  hist [gmm_pkg::WINDOW_DEPTH];
  bit [7:0]  head;
  bit [31:0] count;
  bit        seen;

  motif_result_t awaited_results[$];
  int        errors;
  int        checked;
  int        hits_predicted;

  function new();
    pat1 = '0; len1 = 6'd1; off1 = '0;
    pat2 = '0; len2 = '0;   off2 = '0;
    whole = 9'd1; minus = 1'b0;
    foreach (hist[k]) hist[k] = 3'b000;
    head = '0; count = '0; seen = 1'b0;
    errors = 0; checked = 0; hits_predicted = 0;
  endfunction

  function void set_reg(gmm_pkg::reg_idx_t idx, logic [63:0] data);
    case (idx)
      gmm_pkg::REG_SITE1_PAT: pat1  = data;
      gmm_pkg::REG_SITE1_LEN: len1  = data[5:0];
      gmm_pkg::REG_SITE1_OFF: off1  = data[7:0];
      gmm_pkg::REG_SITE2_PAT: pat2  = data;
      gmm_pkg::REG_SITE2_LEN: len2  = data[5:0];
      gmm_pkg::REG_SITE2_OFF: off2  = data[7:0];
      gmm_pkg::REG_WHOLE_LEN: whole = data[8:0];
      gmm_pkg::REG_MINUS:     minus = data[0];
      default: ;
    endcase
  endfunction

  // clamped lengths and offsets as searched, mirrored on the minus strand
  function void site_layout(output longint l1, output longint o1,
                            output longint l2, output longint o2);
    l1 = (len1 > gmm_pkg::SITE_LEN_MAX) ? gmm_pkg::SITE_LEN_MAX : len1;
    l2 = (len2 > gmm_pkg::SITE_LEN_MAX) ? gmm_pkg::SITE_LEN_MAX : len2;
    o1 = off1;
    o2 = off2;
    if (minus) begin
      o1 = longint'(whole) - o1 - l1;
      o2 = longint'(whole) - o2 - l2;
    end
  endfunction

  function bit [1:0] site_code(bit [63:0] pat, longint len, longint i);
    if (minus) return 2'd3 - pat[2*(len-1-i) +: 2];
    return pat[2*i +: 2];
  endfunction

  function bit [2:0] base_entry(logic [7:0] b);
    bit [2:0] e;
    case (b | 8'h20)
      "a":     e = {1'b1, gmm_pkg::BASE_A};
      "c":     e = {1'b1, gmm_pkg::BASE_C};
      "g":     e = {1'b1, gmm_pkg::BASE_G};
      "t":     e = {1'b1, gmm_pkg::BASE_T};
      default: e = 3'b000;
    endcase
    return e;
  endfunction

  function bit site_hit(bit [63:0] pat, longint len, longint off, longint span_end);
    longint   i, d;
    bit [7:0] slot;
    bit [2:0] e;
    for (i = 0; i < len; i++) begin
      d = span_end - 1 - off - i;
      if (d >= longint'(count) || d >= gmm_pkg::WINDOW_DEPTH) return 1'b0;
      slot = head - d[7:0];
      e = hist[slot];
      if (!e[2] || e[1:0] != site_code(pat, len, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_base(logic [7:0] b, logic s);
    motif_result_t r;
    longint l1, o1, l2, o2, span_end, first_pos;
    if (s) begin
      foreach (hist[k]) hist[k] = 3'b000;
      head = '0; count = '0; seen = 1'b0;
    end
    head = head + 8'd1;
    hist[head] = base_entry(b);
    if (count != 32'hFFFF_FFFF) count = count + 32'd1;
    site_layout(l1, o1, l2, o2);
    span_end = o1 + l1;
    if (l2 != 0 && o2 + l2 > span_end) span_end = o2 + l2;
    first_pos = longint'(count) - span_end;
    r.match = (first_pos >= 0) && site_hit(pat1, l1, o1, span_end) &&
              (l2 == 0 || site_hit(pat2, l2, o2, span_end));
    r.pos = '0;
    if (r.match) begin
      seen = 1'b1;
      hits_predicted++;
      r.pos = (first_pos > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : first_pos[31:0];
    end
    r.any = seen;
    awaited_results.push_back(r);
  endfunction

  function void check_result(logic m, logic [31:0] p, logic a);
    motif_result_t e;
    checked++;
    if (awaited_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result word: match=%0b pos=%0d any=%0b", m, p, a);
      return;
    end
    e = awaited_results.pop_front();
    if (m !== e.match || p !== e.pos || a !== e.any) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on word %0d: expected match=%0b pos=%0d any=%0b, got match=%0b pos=%0d any=%0b",
                 checked, e.match, e.pos, e.any, m, p, a);
    end
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 10;
  localparam int PHASE_BASES  = 140;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [7:0]                   base_byte;
  logic                         sequence_start;
  logic                         out_valid;
  logic                         out_stall;
  logic                         match_found;
  logic [gmm_pkg::COUNT_W-1:0]  start_position;
  logic                         any_match;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [gmm_pkg::IDX_W-1:0]    cfg_index;
  logic [gmm_pkg::PAT_W-1:0]    cfg_data;

  motif_scoreboard motif_sb;
  int              cycle_count;
  int              in_idle_pct;
  int              out_stall_pct;
  int              bases_sent;
  int              settings_applied;
  logic [7:0]      plan_byte[$];
  bit              plan_start[$];

  gapped_motif_matcher u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .base_byte      (base_byte),
    .sequence_start (sequence_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .match_found    (match_found),
    .start_position (start_position),
    .any_match      (any_match),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               motif_sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      motif_sb.check_result(match_found, start_position, any_match);
  end

  task automatic send_base(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    base_byte      <= b;
    sequence_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    motif_sb.note_base(b, s);
    bases_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input gmm_pkg::reg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    motif_sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // all results in, plus room for the pipeline to drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (motif_sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic apply_config(input logic [63:0] p1, input logic [5:0] l1,
                              input logic [7:0] o1, input logic [63:0] p2,
                              input logic [5:0] l2, input logic [7:0] o2,
                              input logic [8:0] w, input logic m);
    wait_idle();
    write_reg(gmm_pkg::REG_SITE1_PAT, p1);
    write_reg(gmm_pkg::REG_SITE1_LEN, 64'(l1));
    write_reg(gmm_pkg::REG_SITE1_OFF, 64'(o1));
    write_reg(gmm_pkg::REG_SITE2_PAT, p2);
    write_reg(gmm_pkg::REG_SITE2_LEN, 64'(l2));
    write_reg(gmm_pkg::REG_SITE2_OFF, 64'(o2));
    write_reg(gmm_pkg::REG_WHOLE_LEN, 64'(w));
    write_reg(gmm_pkg::REG_MINUS,     64'(m));
    cfg_valid <= 1'b0;
    settings_applied++;
    plan_byte.delete();
    plan_start.delete();
  endtask

  function automatic logic [7:0] base_char(bit [1:0] code, bit upper);
    logic [7:0] c;
    case (code)
      gmm_pkg::BASE_A: c = "a";
      gmm_pkg::BASE_C: c = "c";
      gmm_pkg::BASE_G: c = "g";
      default:         c = "t";
    endcase
    return upper ? (c & 8'hDF) : c;
  endfunction

  function automatic logic [63:0] rand_pattern();
    int r;
    r = $urandom_range(11);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 6'd0;
    if (r < 12) return 6'($urandom_range(33, 63));
    if (r < 20) return 6'd32;
    return 6'($urandom_range(1, 10));
  endfunction

  function automatic logic [7:0] rand_off();
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return 8'($urandom_range(12));
  endfunction

  task automatic random_config(input int kind);
    logic [63:0] p1, p2;
    logic [5:0]  l1, l2;
    logic [7:0]  o1, o2;
    logic [8:0]  w;
    int          reach;
    case (kind)
      1: apply_config('1, 6'd63, 8'd255, '1, 6'd63, 8'd255, 9'd511, 1'b1);
      2: apply_config('0, 6'd0, 8'd0, '0, 6'd0, 8'd0, 9'd0, 1'b0);
      3: begin
        // site pushed to the far end of the window
        l1 = 6'($urandom_range(1, 20));
        o1 = 8'($urandom_range(240, 255));
        apply_config(rand_pattern(), l1, o1, '0, 6'd0, 8'd0,
                     9'($urandom_range(511)), 1'b0);
      end
      default: begin
        p1 = rand_pattern();
        p2 = rand_pattern();
        l1 = rand_len();
        o1 = rand_off();
        l2 = ($urandom_range(99) < 35) ? 6'd0 :
             (($urandom_range(9) == 0) ? 6'd32 : 6'($urandom_range(1, 8)));
        o2 = rand_off();
        reach = int'(o1) + int'(l1);
        if (int'(o2) + int'(l2) > reach) reach = int'(o2) + int'(l2);
        reach = reach + $urandom_range(6);
        if (reach > 511 || $urandom_range(9) == 0) reach = $urandom_range(511);
        w = 9'(reach);
        apply_config(p1, l1, o1, p2, l2, o2, w, 1'($urandom_range(1)));
      end
    endcase
  endtask

  task automatic plan_noise();
    int n, k, r;
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 85)      plan_byte.push_back(base_char(2'($urandom_range(3)),
                                                     1'($urandom_range(1))));
      else if (r < 95) plan_byte.push_back(8'($urandom_range(255)));
      else             plan_byte.push_back(($urandom_range(1) != 0) ? "N" : "n");
      plan_start.push_back(1'b0);
    end
  endtask

  // one whole site with the sites laid in, gaps random; sometimes broken
  task automatic plan_motif();
    longint   l1, o1, l2, o2, lo, hi, n, k;
    bit [1:0] img [0:299];
    int       cut;
    motif_sb.site_layout(l1, o1, l2, o2);
    lo = 0;
    if (o1 < lo) lo = o1;
    if (l2 != 0 && o2 < lo) lo = o2;
    hi = o1 + l1;
    if (l2 != 0 && o2 + l2 > hi) hi = o2 + l2;
    n = hi - lo;
    if (n <= 0 || n > 300) begin
      plan_noise();
      return;
    end
    for (k = 0; k < n; k++) img[k] = 2'($urandom_range(3));
    for (k = 0; k < l1; k++) img[o1 + k - lo] = motif_sb.site_code(motif_sb.pat1, l1, k);
    for (k = 0; k < l2; k++) img[o2 + k - lo] = motif_sb.site_code(motif_sb.pat2, l2, k);
    if ($urandom_range(3) == 0) img[$urandom_range(int'(n) - 1)] = 2'($urandom_range(3));
    cut = -1;
    if (n > 1 && $urandom_range(9) == 0) cut = $urandom_range(1, int'(n) - 1);
    for (k = 0; k < n; k++) begin
      plan_byte.push_back(base_char(img[k], 1'($urandom_range(1))));
      plan_start.push_back(k == cut);
    end
  endtask

  task automatic next_base();
    logic [7:0] b;
    bit         s;
    if (plan_byte.size() == 0) begin
      if ($urandom_range(99) < 60) plan_motif();
      else                         plan_noise();
      if ($urandom_range(7) == 0) plan_start[0] = 1'b1;
    end
    b = plan_byte.pop_front();
    s = plan_start.pop_front();
    send_base(b, s);
  endtask

  task automatic set_idling(input int phase);
    if (phase < 4) begin
      in_idle_pct = 7;  out_stall_pct = 69;
    end else if (phase < 7) begin
      in_idle_pct = 69; out_stall_pct = 7;
    end else begin
      in_idle_pct = 0;  out_stall_pct = 0;
    end
  endtask

  initial begin
    motif_sb         = new();
    cycle_count      = 0;
    bases_sent       = 0;
    settings_applied = 0;
    in_idle_pct      = 7;
    out_stall_pct    = 69;
    rst              = 1'b1;
    in_valid         = 1'b0;
    base_byte        = '0;
    sequence_start   = 1'b0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: single-base site 'a', case folding and invalid bytes
    send_base("a", 1'b1);
    send_base("A", 1'b0);
    send_base("c", 1'b0);
    send_base(8'h00, 1'b0);
    send_base(8'hFF, 1'b0);
    send_base("N", 1'b0);
    send_base("a", 1'b0);

    // empty first site matches everywhere; whole length zero, minus strand
    apply_config('0, 6'd0, 8'd0, '0, 6'd0, 8'd0, 9'd0, 1'b1);
    send_base("g", 1'b1);
    send_base("T", 1'b0);

    // mirrored offset goes negative: start lies past the current base
    apply_config(64'h4, 6'd2, 8'd5, '0, 6'd0, 8'd0, 9'd3, 1'b1);
    send_base("g", 1'b1);
    send_base("t", 1'b0);
    send_base("c", 1'b0);

    // two sites with a gap; first hit lands right at sequence start
    apply_config(64'h1, 6'd1, 8'd0, 64'h3, 6'd1, 8'd2, 9'd9, 1'b0);
    send_base("c", 1'b1);
    send_base("g", 1'b0);
    send_base("t", 1'b0);
    send_base("c", 1'b0);
    send_base("a", 1'b0);
    send_base("t", 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      set_idling(phase);
      case (phase)
        1:       random_config(1);
        3:       random_config(3);
        5:       random_config(2);
        default: random_config(0);
      endcase
      plan_byte.push_back(base_char(2'($urandom_range(3)), 1'b0));
      plan_start.push_back(1'b1);
      for (int k = 0; k < PHASE_BASES; k++) next_base();
    end

    in_valid <= 1'b0;
    while (motif_sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d base words under %0d register settings, %0d results checked",
             bases_sent, settings_applied, motif_sb.checked);
    $display("%0d motif hits predicted, %0d mismatches", motif_sb.hits_predicted,
             motif_sb.errors);
    if (motif_sb.errors == 0 && motif_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
